### src/cmfl_pkg.sv
// ============================================================================
// cmfl_pkg: shared types and constants for the cube map face lookup
// Face codes, the sideband tag that travels with an item through the
// divider, and the default sizes of the direction and coordinate fields.
// ============================================================================
package cmfl_pkg;

    // Default sizes; the top level hands them down as parameters.
    localparam int DIR_WIDTH_DEF       = 16;
    localparam int COORD_FRAC_BITS_DEF = 16;

    // Face index width and codes.
    localparam int FACE_W = 3;

    localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
    localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
    localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd2;
    localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd3;
    localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
    localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

    // Sideband that rides along with both coordinate lanes.
    typedef struct packed {
        logic [FACE_W-1:0] face;
        logic              zero;
    } tag_t;

endpackage

### src/cmfl_front.sv
// ============================================================================
// cmfl_front: face selection and dividend setup
// Three register stages: magnitudes, major axis and minor components, then
// the two dividends and the shared divisor for the coordinate dividers.
// ============================================================================
module cmfl_front #(
    parameter int DIR_WIDTH       = cmfl_pkg::DIR_WIDTH_DEF,
    parameter int COORD_FRAC_BITS = cmfl_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // Upstream side
    input  logic                       valid_in,
    output logic                       ready_up,
    input  logic [DIR_WIDTH-1:0]       x_in,
    input  logic [DIR_WIDTH-1:0]       y_in,
    input  logic [DIR_WIDTH-1:0]       z_in,
    // Downstream side
    output logic                       valid_out,
    input  logic                       ready_dn,
    output cmfl_pkg::tag_t             tag_out,
    output logic [DIR_WIDTH:0]         den_out,
    output logic [DIR_WIDTH:0]         rem_u_out,
    output logic [COORD_FRAC_BITS:0]   lq_u_out,
    output logic [DIR_WIDTH:0]         rem_v_out,
    output logic [COORD_FRAC_BITS:0]   lq_v_out
);

    localparam int DW = DIR_WIDTH;
    localparam int F  = COORD_FRAC_BITS;
    localparam int NW = DW + 1 + F;

    // ------------------------------------------------------------------
    // Stage handshake: a stage loads when it is empty or its item leaves.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    assign rdy3     = !v3_reg || ready_dn;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign ready_up = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= valid_in;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: component magnitudes. The most negative input maps to
    // 2^(DW-1), which still fits as an unsigned DW-bit value.
    // ------------------------------------------------------------------
    logic [DW-1:0] x1_reg, y1_reg, z1_reg;
    logic [DW-1:0] ax1_reg, ay1_reg, az1_reg;
    logic [DW-1:0] ax_next, ay_next, az_next;

    assign ax_next = x_in[DW-1] ? (~x_in + 1'b1) : x_in;
    assign ay_next = y_in[DW-1] ? (~y_in + 1'b1) : y_in;
    assign az_next = z_in[DW-1] ? (~z_in + 1'b1) : z_in;

    always_ff @(posedge clk)
    begin
        if (rdy1 && valid_in)
        begin
            x1_reg  <= x_in;
            y1_reg  <= y_in;
            z1_reg  <= z_in;
            ax1_reg <= ax_next;
            ay1_reg <= ay_next;
            az1_reg <= az_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: pick the major axis (z wins ties, then y), the face, the
    // major magnitude and the two sign-adjusted minor components.
    // ------------------------------------------------------------------
    logic signed [DW:0]        xs, ys, zs;
    logic                      z_major, y_major, zero_next;
    cmfl_pkg::tag_t            tag2_next;
    logic [DW-1:0]             maj2_next;
    logic signed [DW:0]        mu2_next, mv2_next;

    assign xs = $signed({x1_reg[DW-1], x1_reg});
    assign ys = $signed({y1_reg[DW-1], y1_reg});
    assign zs = $signed({z1_reg[DW-1], z1_reg});

    assign z_major   = (az1_reg >= ax1_reg) && (az1_reg >= ay1_reg);
    assign y_major   = (ay1_reg >= ax1_reg);
    assign zero_next = (ax1_reg == '0) && (ay1_reg == '0) && (az1_reg == '0);

    always_comb
    begin
        tag2_next.zero = zero_next;
        if (z_major)
        begin
            tag2_next.face = z1_reg[DW-1] ? cmfl_pkg::FACE_NEG_Z : cmfl_pkg::FACE_POS_Z;
            maj2_next      = az1_reg;
            mu2_next       = z1_reg[DW-1] ? -xs : xs;
            mv2_next       = ys;
        end
        else if (y_major)
        begin
            tag2_next.face = y1_reg[DW-1] ? cmfl_pkg::FACE_NEG_Y : cmfl_pkg::FACE_POS_Y;
            maj2_next      = ay1_reg;
            mu2_next       = xs;
            mv2_next       = y1_reg[DW-1] ? zs : -zs;
        end
        else
        begin
            tag2_next.face = x1_reg[DW-1] ? cmfl_pkg::FACE_NEG_X : cmfl_pkg::FACE_POS_X;
            maj2_next      = ax1_reg;
            mu2_next       = x1_reg[DW-1] ? zs : -zs;
            mv2_next       = ys;
        end
    end

    cmfl_pkg::tag_t      tag2_reg;
    logic [DW-1:0]       maj2_reg;
    logic signed [DW:0]  mu2_reg, mv2_reg;

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            tag2_reg <= tag2_next;
            maj2_reg <= maj2_next;
            mu2_reg  <= mu2_next;
            mv2_reg  <= mv2_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: dividend (m + M) * 2^F + M for round to nearest, divisor
    // 2M. The upper dividend bits seed the partial remainder; the lower
    // F+1 bits are shifted in one per divider step.
    // ------------------------------------------------------------------
    logic signed [DW+1:0] sum_u, sum_v;
    logic [NW-1:0]        num_u, num_v;

    assign sum_u = {mu2_reg[DW], mu2_reg} + $signed({2'b00, maj2_reg});
    assign sum_v = {mv2_reg[DW], mv2_reg} + $signed({2'b00, maj2_reg});
    assign num_u = {sum_u[DW:0], {F{1'b0}}} + NW'(maj2_reg);
    assign num_v = {sum_v[DW:0], {F{1'b0}}} + NW'(maj2_reg);

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            tag_out   <= tag2_reg;
            den_out   <= {maj2_reg, 1'b0};
            rem_u_out <= {1'b0, num_u[NW-1:F+1]};
            lq_u_out  <= num_u[F:0];
            rem_v_out <= {1'b0, num_v[NW-1:F+1]};
            lq_v_out  <= num_v[F:0];
        end
    end

    assign valid_out = v3_reg;

endmodule

### src/cmfl_div_step.sv
// ============================================================================
// cmfl_div_step: one restoring division step for both coordinate lanes
// Shifts one dividend bit into each partial remainder, subtracts the shared
// divisor where it fits and shifts the quotient bit in from the bottom.
// ============================================================================
module cmfl_div_step #(
    parameter int DIR_WIDTH       = cmfl_pkg::DIR_WIDTH_DEF,
    parameter int COORD_FRAC_BITS = cmfl_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       valid_in,
    output logic                       ready_up,
    input  cmfl_pkg::tag_t             tag_in,
    input  logic [DIR_WIDTH:0]         den_in,
    input  logic [DIR_WIDTH:0]         rem_u_in,
    input  logic [COORD_FRAC_BITS:0]   lq_u_in,
    input  logic [DIR_WIDTH:0]         rem_v_in,
    input  logic [COORD_FRAC_BITS:0]   lq_v_in,
    output logic                       valid_out,
    input  logic                       ready_dn,
    output cmfl_pkg::tag_t             tag_out,
    output logic [DIR_WIDTH:0]         den_out,
    output logic [DIR_WIDTH:0]         rem_u_out,
    output logic [COORD_FRAC_BITS:0]   lq_u_out,
    output logic [DIR_WIDTH:0]         rem_v_out,
    output logic [COORD_FRAC_BITS:0]   lq_v_out
);

    localparam int DW = DIR_WIDTH;
    localparam int F  = COORD_FRAC_BITS;

    logic valid_reg;

    assign ready_up  = !valid_reg || ready_dn;
    assign valid_out = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_up)
        begin
            valid_reg <= valid_in;
        end
    end

    // Trial subtraction on both lanes against the same divisor.
    logic [DW+1:0] trial_u, trial_v, diff_u, diff_v;
    logic          fit_u, fit_v;

    assign trial_u = {rem_u_in, lq_u_in[F]};
    assign trial_v = {rem_v_in, lq_v_in[F]};
    assign diff_u  = trial_u - {1'b0, den_in};
    assign diff_v  = trial_v - {1'b0, den_in};
    assign fit_u   = (trial_u >= {1'b0, den_in});
    assign fit_v   = (trial_v >= {1'b0, den_in});

    always_ff @(posedge clk)
    begin
        if (ready_up && valid_in)
        begin
            tag_out   <= tag_in;
            den_out   <= den_in;
            rem_u_out <= fit_u ? diff_u[DW:0] : trial_u[DW:0];
            rem_v_out <= fit_v ? diff_v[DW:0] : trial_v[DW:0];
            lq_u_out  <= {lq_u_in[F-1:0], fit_u};
            lq_v_out  <= {lq_v_in[F-1:0], fit_v};
        end
    end

endmodule

### src/cmfl_divider.sv
// ============================================================================
// cmfl_divider: pipelined two-lane restoring divider
// A chain of COORD_FRAC_BITS+1 step stages, one quotient bit per stage.
// ============================================================================
module cmfl_divider #(
    parameter int DIR_WIDTH       = cmfl_pkg::DIR_WIDTH_DEF,
    parameter int COORD_FRAC_BITS = cmfl_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       valid_in,
    output logic                       ready_up,
    input  cmfl_pkg::tag_t             tag_in,
    input  logic [DIR_WIDTH:0]         den_in,
    input  logic [DIR_WIDTH:0]         rem_u_in,
    input  logic [COORD_FRAC_BITS:0]   lq_u_in,
    input  logic [DIR_WIDTH:0]         rem_v_in,
    input  logic [COORD_FRAC_BITS:0]   lq_v_in,
    output logic                       valid_out,
    input  logic                       ready_dn,
    output cmfl_pkg::tag_t             tag_out,
    output logic [COORD_FRAC_BITS:0]   quo_u,
    output logic [COORD_FRAC_BITS:0]   quo_v
);

    localparam int DW    = DIR_WIDTH;
    localparam int F     = COORD_FRAC_BITS;
    localparam int STEPS = F + 1;

    // Links between stages; index 0 is the chain input.
    logic               vld_w [0:STEPS];
    logic               rdy_w [0:STEPS];
    cmfl_pkg::tag_t     tag_w [0:STEPS];
    logic [DW:0]        den_w [0:STEPS];
    logic [DW:0]        ru_w  [0:STEPS];
    logic [DW:0]        rv_w  [0:STEPS];
    logic [F:0]         qu_w  [0:STEPS];
    logic [F:0]         qv_w  [0:STEPS];

    assign vld_w[0]     = valid_in;
    assign tag_w[0]     = tag_in;
    assign den_w[0]     = den_in;
    assign ru_w[0]      = rem_u_in;
    assign rv_w[0]      = rem_v_in;
    assign qu_w[0]      = lq_u_in;
    assign qv_w[0]      = lq_v_in;
    assign ready_up     = rdy_w[0];
    assign rdy_w[STEPS] = ready_dn;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        cmfl_div_step #(
            .DIR_WIDTH       (DIR_WIDTH),
            .COORD_FRAC_BITS (COORD_FRAC_BITS)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (vld_w[i]),
            .ready_up  (rdy_w[i]),
            .tag_in    (tag_w[i]),
            .den_in    (den_w[i]),
            .rem_u_in  (ru_w[i]),
            .lq_u_in   (qu_w[i]),
            .rem_v_in  (rv_w[i]),
            .lq_v_in   (qv_w[i]),
            .valid_out (vld_w[i+1]),
            .ready_dn  (rdy_w[i+1]),
            .tag_out   (tag_w[i+1]),
            .den_out   (den_w[i+1]),
            .rem_u_out (ru_w[i+1]),
            .lq_u_out  (qu_w[i+1]),
            .rem_v_out (rv_w[i+1]),
            .lq_v_out  (qv_w[i+1])
        );
    end

    // The final remainders and divisor are not needed past the last step.
    assign valid_out = vld_w[STEPS];
    assign tag_out   = tag_w[STEPS];
    assign quo_u     = qu_w[STEPS];
    assign quo_v     = qv_w[STEPS];

endmodule

### src/cube_map_face_lookup_core.sv
// ============================================================================
// cube_map_face_lookup_core: cube map face and face coordinate lookup
// Picks the cube face for a signed direction and maps the two minor
// components to rounded, saturated unsigned face coordinates.
// ============================================================================
//
//  Channel   Dir  Handshake                  Payload (lowest bits first)
//  s_axis    in   s_axis_tvalid/tready       tdata: dir_x, dir_y, dir_z
//  m_axis    out  m_axis_tvalid/tready       tdata: face, coord_u, coord_v
//                                            tuser: zero_direction
//
//  One item enters per cycle unless the input side stalls. Three front
//  stages perform face selection and dividend setup, then the two-lane
//  restoring divider follows with one stage per quotient bit for both lanes.
//  Reset clears all stage valid bits; payload registers are not reset.
//  Every stage holds its item while the stage after it is full and stalled,
//  and empty stages keep loading, so a stall drops and repeats nothing.
//
module cube_map_face_lookup_core #(
    parameter int DIR_WIDTH       = cmfl_pkg::DIR_WIDTH_DEF,
    parameter int COORD_FRAC_BITS = cmfl_pkg::COORD_FRAC_BITS_DEF,
    parameter int IN_W            = ((3 * DIR_WIDTH + 7) / 8) * 8,
    parameter int OUT_FIELDS_W    = cmfl_pkg::FACE_W + 2 * (COORD_FRAC_BITS + 1),
    parameter int OUT_W           = ((OUT_FIELDS_W + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // dir_x, dir_y, dir_z
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // face, coord_u, coord_v, zero pad
    output logic             m_axis_tuser    // zero_direction
);

    localparam int DW = DIR_WIDTH;
    localparam int F  = COORD_FRAC_BITS;

    // Front end to divider link.
    logic                 fe_valid, fe_ready;
    cmfl_pkg::tag_t       fe_tag;
    logic [DW:0]          fe_den, fe_rem_u, fe_rem_v;
    logic [F:0]           fe_lq_u, fe_lq_v;

    cmfl_front #(
        .DIR_WIDTH       (DIR_WIDTH),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s_axis_tvalid),
        .ready_up  (s_axis_tready),
        .x_in      (s_axis_tdata[DW-1:0]),
        .y_in      (s_axis_tdata[2*DW-1:DW]),
        .z_in      (s_axis_tdata[3*DW-1:2*DW]),
        .valid_out (fe_valid),
        .ready_dn  (fe_ready),
        .tag_out   (fe_tag),
        .den_out   (fe_den),
        .rem_u_out (fe_rem_u),
        .lq_u_out  (fe_lq_u),
        .rem_v_out (fe_rem_v),
        .lq_v_out  (fe_lq_v)
    );

    cmfl_pkg::tag_t       dv_tag;
    logic [F:0]           quo_u, quo_v;

    cmfl_divider #(
        .DIR_WIDTH       (DIR_WIDTH),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (fe_valid),
        .ready_up  (fe_ready),
        .tag_in    (fe_tag),
        .den_in    (fe_den),
        .rem_u_in  (fe_rem_u),
        .lq_u_in   (fe_lq_u),
        .rem_v_in  (fe_rem_v),
        .lq_v_in   (fe_lq_v),
        .valid_out (m_axis_tvalid),
        .ready_dn  (m_axis_tready),
        .tag_out   (dv_tag),
        .quo_u     (quo_u),
        .quo_v     (quo_v)
    );

    // ------------------------------------------------------------------
    // Result formatting: saturate at 1.0 and force a zero direction to
    // face +x with both coordinates at zero.
    // ------------------------------------------------------------------
    localparam logic [F:0] COORD_ONE = {1'b1, {F{1'b0}}};

    logic [F:0]                     coord_u, coord_v;
    logic [cmfl_pkg::FACE_W-1:0]    face;

    assign coord_u = dv_tag.zero ? '0 : ((quo_u > COORD_ONE) ? COORD_ONE : quo_u);
    assign coord_v = dv_tag.zero ? '0 : ((quo_v > COORD_ONE) ? COORD_ONE : quo_v);
    assign face    = dv_tag.zero ? cmfl_pkg::FACE_POS_X : dv_tag.face;

    assign m_axis_tdata = {{(OUT_W - OUT_FIELDS_W){1'b0}}, coord_v, coord_u, face};
    assign m_axis_tuser = dv_tag.zero;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // The input side only stalls when the pipeline is full up to the output.
    a_stall_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid
    ) else $error("input stalled while the output stage is empty");

    // A nonzero direction never divides past 1.0 before saturation.
    a_quotient_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !dv_tag.zero) |-> (quo_u <= COORD_ONE) && (quo_v <= COORD_ONE)
    ) else $error("divider quotient above one");

    // The face code leaving the pipeline is always a real face.
    a_face_legal: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (dv_tag.face <= cmfl_pkg::FACE_NEG_Z)
    ) else $error("illegal face code at output");

endmodule
